>>> hw/rtl/cpr_pkg.sv
// Shared types and constants for the clock page-replacement core.
package cpr_pkg;

  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_CLAIM  = 2'd1;
  localparam logic [1:0] REQ_GET    = 2'd2;

  typedef enum logic [1:0] {
    RES_ECHO,
    RES_FREE,
    RES_EVICT
  } res_sel_e;

  // Per-frame entry held in the frame RAM.
  typedef struct packed {
    logic ref_b;
    logic dirty_b;
    logic file_b;
  } ent_t;

  typedef struct packed {
    logic     clr_wr;
    logic     capture;
    logic     rd;
    logic     rd_sweep;
    logic     acc_wr;
    logic     claim;
    logic     sweep_init;
    logic     sw_clear;
    logic     evict;
    logic     finish;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_access;
    logic is_claim;
    logic is_get;
    logic frame_ok;
    logic stack_empty;
    logic ref_bit;
  } status_t;

endpackage

>>> hw/rtl/cpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpr_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cpr_ctrl.sv
// Controller state machine: sequences clearing, decode, access and clock sweep.
module cpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cpr_pkg::status_t status_i,
  output cpr_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_ACC_WR = 3'd3;
  localparam logic [2:0] S_SW_RD  = 3'd4;
  localparam logic [2:0] S_SW_EV  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = cpr_pkg::RES_ECHO;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status_i.is_access && status_i.frame_ok) begin
          cmd_o.rd = 1'b1;
          state_d  = S_ACC_WR;
        end else if (status_i.is_claim && status_i.frame_ok && !status_i.stack_empty) begin
          cmd_o.claim  = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.is_get && !status_i.stack_empty) begin
          cmd_o.finish  = 1'b1;
          cmd_o.res_sel = cpr_pkg::RES_FREE;
          state_d       = S_IDLE;
        end else if (status_i.is_get) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = S_SW_RD;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ACC_WR: begin
        cmd_o.acc_wr = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_SW_RD: begin
        cmd_o.rd       = 1'b1;
        cmd_o.rd_sweep = 1'b1;
        state_d        = S_SW_EV;
      end
      S_SW_EV: begin
        if (status_i.ref_bit) begin
          cmd_o.sw_clear = 1'b1;
          state_d        = S_SW_RD;
        end else begin
          cmd_o.evict   = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.res_sel = cpr_pkg::RES_EVICT;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_finish_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !cmd_o.finish)
    else $error("back-to-back finish");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !(cmd_o.clr_wr || cmd_o.acc_wr || cmd_o.claim || cmd_o.sw_clear
                  || cmd_o.evict))
    else $error("frame RAM written while idle");

endmodule

>>> hw/rtl/cpr_dp.sv
// Datapath: frame RAM, free-stack top, count, clock hand and result registers.
module cpr_dp #(
  parameter int FRAMES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       req_type_i,
  input  logic [5:0]       frame_i,
  input  logic             is_write_i,
  input  logic             file_backed_i,
  input  cpr_pkg::cmd_t    cmd_i,
  output cpr_pkg::status_t status_o,
  output logic [5:0]       result_frame_o,
  output logic             evicted_o,
  output logic             needs_writeback_o,
  output logic             was_file_backed_o,
  output logic             done_o
);

  localparam int FW = $clog2(FRAMES);
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);
  localparam logic [FW-1:0] FIRST_FRAME = FW'(1);

  logic [1:0]    req_q;
  logic [5:0]    frame_q;
  logic          wr_q, fb_q;
  logic [FW-1:0] count_q, count_d;
  logic [FW-1:0] top0_q, top0_d;
  logic [FW-1:0] hand_q, hand_d;
  logic [FW-1:0] h_q, h_d;
  logic [FW-1:0] clr_q, clr_d;
  logic [5:0]    res_frame_q;
  logic          ev_q, wb_q, wf_q;
  logic          done_q;

  logic [FW-1:0]  fidx, h_next, free_top;
  logic           ram_we;
  logic [FW-1:0]  ram_waddr, ram_raddr;
  cpr_pkg::ent_t  ram_wdata, ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      frame_q <= frame_i;
      wr_q    <= is_write_i;
      fb_q    <= file_backed_i;
    end
  end

  assign fidx     = FW'(frame_q);
  assign h_next   = (h_q == LAST_FRAME) ? FIRST_FRAME : h_q + FIRST_FRAME;
  // stack above index 0 is never rewritten: entry k >= 1 holds FRAMES-1-k
  assign free_top = (count_q == FIRST_FRAME) ? top0_q : LAST_FRAME + FIRST_FRAME - count_q;

  assign status_o.clr_last    = (clr_q == LAST_FRAME);
  assign status_o.is_access   = (req_q == cpr_pkg::REQ_ACCESS);
  assign status_o.is_claim    = (req_q == cpr_pkg::REQ_CLAIM);
  assign status_o.is_get      = (req_q == cpr_pkg::REQ_GET);
  assign status_o.frame_ok    = (frame_q != 6'd0) && (32'(frame_q) < 32'(FRAMES));
  assign status_o.stack_empty = (count_q == '0);
  assign status_o.ref_bit     = ram_rdata.ref_b;

  assign ram_we = cmd_i.clr_wr | cmd_i.acc_wr | cmd_i.claim | cmd_i.sw_clear | cmd_i.evict;
  assign ram_raddr = cmd_i.rd_sweep ? h_q : fidx;

  always_comb begin
    ram_waddr = fidx;
    ram_wdata = '0;
    priority if (cmd_i.clr_wr) begin
      ram_waddr = clr_q;
    end else if (cmd_i.sw_clear) begin
      ram_waddr = h_q;
      ram_wdata = '{ref_b: 1'b0, dirty_b: ram_rdata.dirty_b, file_b: ram_rdata.file_b};
    end else if (cmd_i.evict) begin
      ram_waddr = h_q;
    end else if (cmd_i.acc_wr) begin
      ram_wdata = '{ref_b: 1'b1, dirty_b: ram_rdata.dirty_b | wr_q,
                    file_b: ram_rdata.file_b};
    end else if (cmd_i.claim) begin
      ram_wdata = '{ref_b: 1'b1, dirty_b: 1'b0, file_b: fb_q};
    end else begin
      ram_wdata = '0;
    end
  end

  cpr_ram #(
    .WIDTH ($bits(cpr_pkg::ent_t)),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    top0_d  = top0_q;
    hand_d  = hand_q;
    h_d     = h_q;
    clr_d   = clr_q;
    if (cmd_i.clr_wr) begin
      clr_d = clr_q + FIRST_FRAME;
    end
    if (cmd_i.claim) begin
      count_d = count_q - FIRST_FRAME;
    end
    if (cmd_i.sweep_init) begin
      h_d = hand_q;
    end
    if (cmd_i.sw_clear) begin
      h_d = h_next;
    end
    if (cmd_i.evict) begin
      count_d = FIRST_FRAME;
      top0_d  = h_q;
      hand_d  = h_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= LAST_FRAME;
      top0_q  <= LAST_FRAME;
      hand_q  <= FIRST_FRAME;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      top0_q  <= top0_d;
      hand_q  <= hand_d;
      clr_q   <= clr_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (cmd_i.finish) begin
      unique case (cmd_i.res_sel)
        cpr_pkg::RES_FREE: begin
          res_frame_q <= 6'(free_top);
          ev_q <= 1'b0;
          wb_q <= 1'b0;
          wf_q <= 1'b0;
        end
        cpr_pkg::RES_EVICT: begin
          res_frame_q <= 6'(h_q);
          ev_q <= 1'b1;
          wb_q <= ram_rdata.dirty_b;
          wf_q <= ram_rdata.file_b;
        end
        default: begin
          res_frame_q <= frame_q;
          ev_q <= 1'b0;
          wb_q <= 1'b0;
          wf_q <= 1'b0;
        end
      endcase
    end
  end

  assign result_frame_o    = res_frame_q;
  assign evicted_o         = ev_q;
  assign needs_writeback_o = wb_q;
  assign was_file_backed_o = wf_q;
  assign done_o            = done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LAST_FRAME)
    else $error("free count above managed frames");

  a_hand_managed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_q != '0 && hand_q <= LAST_FRAME)
    else $error("clock hand off managed range");

  a_evict_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && ev_q) |-> (count_q == FIRST_FRAME && 6'(top0_q) == res_frame_q))
    else $error("evicted frame not on free stack");

endmodule

>>> hw/rtl/clock_page_replacement_core.sv
// Clock (second-chance) page-replacement frame picker, top level.
//
// Request channel: req_type_i, frame_i, is_write_i, file_backed_i are taken
// at a rising edge with start_i high and busy_o low. Each request gives one
// result on result_frame_o, evicted_o, needs_writeback_o, was_file_backed_o,
// valid for the single cycle in which done_o is high; the receiver cannot
// stall, so the result must be taken then.
// Claims, gets from the free stack and ignored requests finish from the decode
// state; an access adds a write state (read-modify-write of the frame RAM);
// a get that sweeps passes through S_SW_RD and S_SW_EV for each frame the
// hand visits (1 to FRAMES). The sweep reads and rewrites one frame RAM
// entry at a time through its registered read port.
// busy_o falls in the cycle done_o rises, so the next request can be taken
// then.
// After reset, busy_o stays high while the frame RAM is cleared one entry per
// cycle; the free stack then holds frames 1 to FRAMES-1 with frame 1 on top
// and the hand rests on frame 1.
module clock_page_replacement_core #(
  parameter int FRAMES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [5:0] frame_i,
  input  logic       is_write_i,
  input  logic       file_backed_i,
  output logic       done_o,
  output logic [5:0] result_frame_o,
  output logic       evicted_o,
  output logic       needs_writeback_o,
  output logic       was_file_backed_o
);

  cpr_pkg::cmd_t    cmd;
  cpr_pkg::status_t status;

  cpr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  cpr_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_type_i        (req_type_i),
    .frame_i           (frame_i),
    .is_write_i        (is_write_i),
    .file_backed_i     (file_backed_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .result_frame_o    (result_frame_o),
    .evicted_o         (evicted_o),
    .needs_writeback_o (needs_writeback_o),
    .was_file_backed_o (was_file_backed_o),
    .done_o            (done_o)
  );

endmodule
